/* src/tbf_pkg.sv */
// ----------------------------------------------------------------------------
// tbf_pkg
// shared constants, control struct and spatial weight rom of the filter
// ----------------------------------------------------------------------------
package tbf_pkg;

    localparam int MAX_W    = 128;
    localparam int MAX_H    = 128;
    localparam int MAX_R    = 7;
    localparam int ADDR_W   = 14;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_THRESH = 2'd3;

    // per-request control toward the channel datapaths
    typedef struct packed {
        logic clr;
        logic ctr_ld;
        logic nb_ld;
        logic fin_ld;
    } t_chan_ctrl;

    // q0.16 spatial weight by radius and squared distance, zero past five
    function automatic logic [15:0] spatial_weight(input logic [2:0] r, input logic [3:0] d2);
        logic [15:0] g;
        g = 16'd0;
        unique case (d2)
            4'd0: g = 16'd65535;
            4'd1: begin
                unique case (r)
                    3'd2: g = 16'd34;
                    3'd3: g = 16'd420;
                    3'd4: g = 16'd1484;
                    3'd5: g = 16'd3165;
                    3'd6: g = 16'd5245;
                    3'd7: g = 16'd7524;
                    default: g = 16'd0;
                endcase
            end
            4'd2: begin
                unique case (r)
                    3'd3: g = 16'd3;
                    3'd4: g = 16'd34;
                    3'd5: g = 16'd153;
                    3'd6: g = 16'd420;
                    3'd7: g = 16'd864;
                    default: g = 16'd0;
                endcase
            end
            4'd4: begin
                unique case (r)
                    3'd6: g = 16'd3;
                    3'd7: g = 16'd11;
                    default: g = 16'd0;
                endcase
            end
            4'd5: g = (r == 3'd7) ? 16'd1 : 16'd0;
            default: g = 16'd0;
        endcase
        return g;
    endfunction

endpackage

/* src/tileable_bilateral_filter.sv */
// ----------------------------------------------------------------------------
// tileable_bilateral_filter
// four-channel bilateral filter with wrap-around edges over a pixel store
// ----------------------------------------------------------------------------
// A write request (req_type 0) stores one pixel in the cycle it is accepted and
// never raises busy. A filter request (req_type 1) raises busy until its result
// appears on the o_out_* ports with o_strobe high for one cycle; the receiver
// cannot stall, so take the result in that cycle. Only neighbors within squared
// distance five have a nonzero spatial weight, so the window walked is 3x3 at
// radius 1 and 5x5 at larger radii. Each neighbor takes one store read, a
// 16-step divider for the range weight (four channels side by side), two
// multiplies and the accumulate. Besides the neighbors, a filter request walks
// the 7-step wrap of the center, the center read, the steps back to the window
// corner and a 17-step final divide; o_strobe rises in the same cycle that busy
// falls.
// ----------------------------------------------------------------------------
module tileable_bilateral_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [6:0]         i_pos_x,
    input  logic [6:0]         i_pos_y,
    input  logic signed [15:0] i_in_ch0,
    input  logic signed [15:0] i_in_ch1,
    input  logic signed [15:0] i_in_ch2,
    input  logic signed [15:0] i_in_ch3,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [6:0]         o_out_x,
    output logic [6:0]         o_out_y,
    output logic signed [15:0] o_out_ch0,
    output logic signed [15:0] o_out_ch1,
    output logic signed [15:0] o_out_ch2,
    output logic signed [15:0] o_out_ch3
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MOD  = 4'd1;
    localparam logic [3:0] ST_CRD  = 4'd2;
    localparam logic [3:0] ST_CLT  = 4'd3;
    localparam logic [3:0] ST_ORG  = 4'd4;
    localparam logic [3:0] ST_NRD  = 4'd5;
    localparam logic [3:0] ST_NLD  = 4'd6;
    localparam logic [3:0] ST_NWT  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_FWT  = 4'd9;

    logic [7:0]  r_cfg_w;
    logic [7:0]  r_cfg_h;
    logic [2:0]  r_cfg_r;
    logic [15:0] r_cfg_t;

    logic [3:0]  r_state;
    logic [2:0]  r_cnt;
    logic [6:0]  r_cx;
    logic [6:0]  r_cy;
    logic [6:0]  r_nx;
    logic [6:0]  r_ny;
    logic [6:0]  r_x0;
    logic [2:0]  r_ix;
    logic [2:0]  r_iy;

    logic [7:0]  w_img;
    logic [7:0]  h_img;
    logic [2:0]  r_cl;
    logic [2:0]  re;
    logic [2:0]  last;
    logic [15:0] thr;
    logic [7:0]  mx2;
    logic [7:0]  my2;
    logic [2:0]  adx;
    logic [2:0]  ady;
    logic [3:0]  d2;
    logic [15:0] g;
    logic [63:0] rdata;
    logic [tbf_pkg::ADDR_W-1:0] raddr;
    logic        wr;
    logic [3:0]  done;
    tbf_pkg::t_chan_ctrl ctrl;

    // clamped configuration
    assign w_img = (r_cfg_w == 8'd0) ? 8'd1 :
                   (r_cfg_w > 8'(tbf_pkg::MAX_W)) ? 8'(tbf_pkg::MAX_W) : r_cfg_w;
    assign h_img = (r_cfg_h == 8'd0) ? 8'd1 :
                   (r_cfg_h > 8'(tbf_pkg::MAX_H)) ? 8'(tbf_pkg::MAX_H) : r_cfg_h;
    assign r_cl  = (r_cfg_r == 3'd0) ? 3'd1 : r_cfg_r;
    assign re    = (r_cl >= 3'd2) ? 3'd2 : 3'd1;
    assign last  = {re[1:0], 1'b0};
    assign thr   = (r_cfg_t == 16'd0) ? 16'd1 : r_cfg_t;

    assign busy = (r_state != ST_IDLE);
    assign wr   = start && !busy && !i_req_type;

    // remainder step of pos mod size, msb first
    assign mx2 = {r_cx, o_out_x[r_cnt]};
    assign my2 = {r_cy, o_out_y[r_cnt]};

    // window offset magnitudes for the weight rom
    assign adx = (r_ix >= re) ? r_ix - re : re - r_ix;
    assign ady = (r_iy >= re) ? r_iy - re : re - r_iy;
    assign d2  = 4'(adx * adx) + 4'(ady * ady);
    assign g   = tbf_pkg::spatial_weight(r_cl, d2);

    assign raddr = (r_state == ST_CRD) ? {r_cy, r_cx} : {r_ny, r_nx};

    always_comb begin
        ctrl        = '0;
        ctrl.clr    = (r_state == ST_CLT);
        ctrl.ctr_ld = (r_state == ST_CLT);
        ctrl.nb_ld  = (r_state == ST_NLD);
        ctrl.fin_ld = (r_state == ST_FIN);
    end

    tbf_ram #(
        .WIDTH(64),
        .DEPTH(tbf_pkg::MAX_W * tbf_pkg::MAX_H)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr({i_pos_y, i_pos_x}),
        .i_wdata({i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    tbf_chan u_ch0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_pix(rdata[15:0]),
                    .i_g(g), .i_thr(thr), .o_done(done[0]), .o_val(o_out_ch0));
    tbf_chan u_ch1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_pix(rdata[31:16]),
                    .i_g(g), .i_thr(thr), .o_done(done[1]), .o_val(o_out_ch1));
    tbf_chan u_ch2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_pix(rdata[47:32]),
                    .i_g(g), .i_thr(thr), .o_done(done[2]), .o_val(o_out_ch2));
    tbf_chan u_ch3 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_pix(rdata[63:48]),
                    .i_g(g), .i_thr(thr), .o_done(done[3]), .o_val(o_out_ch3));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 8'd128;
            r_cfg_h <= 8'd128;
            r_cfg_r <= 3'd1;
            r_cfg_t <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tbf_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data[7:0];
                tbf_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data[7:0];
                tbf_pkg::REG_RADIUS: r_cfg_r <= i_cfg_data[2:0];
                tbf_pkg::REG_THRESH: r_cfg_t <= i_cfg_data;
                default:             r_cfg_t <= r_cfg_t;
            endcase
        end
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start && i_req_type) begin
                        o_out_x <= i_pos_x;
                        o_out_y <= i_pos_y;
                        r_cx    <= 7'd0;
                        r_cy    <= 7'd0;
                        r_cnt   <= 3'd6;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    r_cx <= (mx2 >= w_img) ? 7'(mx2 - w_img) : mx2[6:0];
                    r_cy <= (my2 >= h_img) ? 7'(my2 - h_img) : my2[6:0];
                    r_cnt <= r_cnt - 3'd1;
                    if (r_cnt == 3'd0) begin
                        r_state <= ST_CRD;
                    end
                end
                ST_CRD: begin
                    // center read issued here
                    r_nx    <= r_cx;
                    r_ny    <= r_cy;
                    r_cnt   <= re;
                    r_state <= ST_CLT;
                end
                ST_CLT: begin
                    r_state <= ST_ORG;
                end
                ST_ORG: begin
                    // step back to the top-left corner of the window, wrapping
                    r_nx  <= (r_nx == 7'd0) ? 7'(w_img - 8'd1) : r_nx - 7'd1;
                    r_x0  <= (r_nx == 7'd0) ? 7'(w_img - 8'd1) : r_nx - 7'd1;
                    r_ny  <= (r_ny == 7'd0) ? 7'(h_img - 8'd1) : r_ny - 7'd1;
                    r_cnt <= r_cnt - 3'd1;
                    r_ix  <= 3'd0;
                    r_iy  <= 3'd0;
                    if (r_cnt == 3'd1) begin
                        r_state <= ST_NRD;
                    end
                end
                ST_NRD: begin
                    r_state <= ST_NLD;
                end
                ST_NLD: begin
                    r_state <= ST_NWT;
                end
                ST_NWT: begin
                    if (done[0]) begin
                        if (r_ix == last) begin
                            r_ix <= 3'd0;
                            r_nx <= r_x0;
                            r_ny <= (8'(r_ny) + 8'd1 == h_img) ? 7'd0 : r_ny + 7'd1;
                            r_iy <= r_iy + 3'd1;
                            r_state <= (r_iy == last) ? ST_FIN : ST_NRD;
                        end else begin
                            r_ix <= r_ix + 3'd1;
                            r_nx <= (8'(r_nx) + 8'd1 == w_img) ? 7'd0 : r_nx + 7'd1;
                            r_state <= ST_NRD;
                        end
                    end
                end
                ST_FIN: begin
                    r_state <= ST_FWT;
                end
                ST_FWT: begin
                    if (done[0]) begin
                        o_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // all channels run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done[0] |-> (done == 4'hF))
        else $error("channel datapaths out of step");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done[0] |-> (r_state == ST_NWT || r_state == ST_FWT))
        else $error("channel done outside a wait state");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_FWT && !busy))
        else $error("result strobe without final divide");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |-> (r_state == ST_IDLE))
        else $error("store write while filtering");

endmodule

/* src/tbf_ram.sv */
// ----------------------------------------------------------------------------
// tbf_ram
// simple dual-port ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module tbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/tbf_chan.sv */
// ----------------------------------------------------------------------------
// tbf_chan
// one channel: range weight divider, weight multiply, sums, final divider
// ----------------------------------------------------------------------------
module tbf_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbf_pkg::t_chan_ctrl i_ctrl,
    input  logic signed [15:0]  i_pix,
    input  logic [15:0]         i_g,
    input  logic [15:0]         i_thr,
    output logic                o_done,
    output logic signed [15:0]  o_val
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_DIV  = 3'd1;
    localparam logic [2:0] M_MW   = 3'd2;
    localparam logic [2:0] M_MP   = 3'd3;
    localparam logic [2:0] M_ACC  = 3'd4;
    localparam logic [2:0] M_FDIV = 3'd5;
    localparam logic [2:0] M_FOUT = 3'd6;

    logic [2:0]         r_mode;
    logic [4:0]         r_cnt;
    logic signed [15:0] r_ctr;
    logic signed [15:0] r_p;
    logic [15:0]        r_g;
    logic [15:0]        r_rem;
    logic [15:0]        r_q;
    logic               r_full;
    logic [32:0]        r_w;
    logic signed [49:0] r_wp;
    logic [38:0]        r_sw;
    logic signed [55:0] r_sp;
    logic               r_neg;
    logic [16:0]        r_nlo;
    logic [39:0]        r_frem;
    logic [16:0]        r_fq;

    logic signed [16:0] diff;
    logic [15:0]        ad;
    logic [16:0]        rem2;
    logic [55:0]        mag;
    logic [57:0]        fnum;
    logic [39:0]        fden;
    logic [40:0]        frem2;
    logic [16:0]        s_val;

    assign diff  = 17'(r_ctr) - 17'(i_pix);
    assign ad    = diff[16] ? 16'(-diff) : diff[15:0];
    assign rem2  = {r_rem, 1'b0};
    assign mag   = r_sp[55] ? 56'(-r_sp) : 56'(r_sp);
    assign fnum  = {1'b0, mag, 1'b0} + 58'(r_sw);
    assign fden  = {r_sw, 1'b0};
    assign frem2 = {r_frem, r_nlo[16]};
    assign s_val = r_full ? 17'h10000 : {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_mode)
                M_DIV: begin
                    if (rem2 >= 17'(i_thr)) begin
                        r_rem <= 16'(rem2 - 17'(i_thr));
                        r_q   <= {r_q[14:0], 1'b1};
                    end else begin
                        r_rem <= rem2[15:0];
                        r_q   <= {r_q[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_mode <= M_MW;
                    end
                end
                M_MW: begin
                    r_w    <= 33'(s_val * r_g);
                    r_mode <= M_MP;
                end
                M_MP: begin
                    r_wp   <= 50'($signed({1'b0, r_w}) * r_p);
                    r_mode <= M_ACC;
                end
                M_ACC: begin
                    r_sw   <= r_sw + 39'(r_w);
                    r_sp   <= r_sp + 56'(r_wp);
                    r_mode <= M_IDLE;
                    o_done <= 1'b1;
                end
                M_FDIV: begin
                    // restoring step, one quotient bit per cycle
                    if (frem2 >= 41'(fden)) begin
                        r_frem <= 40'(frem2 - 41'(fden));
                        r_fq   <= {r_fq[15:0], 1'b1};
                    end else begin
                        r_frem <= frem2[39:0];
                        r_fq   <= {r_fq[15:0], 1'b0};
                    end
                    r_nlo <= {r_nlo[15:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_mode <= M_FOUT;
                    end
                end
                M_FOUT: begin
                    if (!r_neg) begin
                        o_val <= (r_fq > 17'd32767) ? 16'sd32767 : $signed(r_fq[15:0]);
                    end else begin
                        o_val <= (r_fq >= 17'd32768) ? -16'sd32768 : $signed(16'(-r_fq));
                    end
                    r_mode <= M_IDLE;
                    o_done <= 1'b1;
                end
                default: begin
                    if (i_ctrl.nb_ld) begin
                        r_p    <= i_pix;
                        r_g    <= i_g;
                        r_q    <= 16'd0;
                        r_cnt  <= 5'd0;
                        r_full <= (ad == 16'd0);
                        r_rem  <= (ad > i_thr) ? 16'd0 : i_thr - ad;
                        r_mode <= M_DIV;
                    end else if (i_ctrl.fin_ld) begin
                        r_neg  <= r_sp[55];
                        r_frem <= fnum[56:17];
                        r_nlo  <= fnum[16:0];
                        r_fq   <= 17'd0;
                        r_cnt  <= 5'd0;
                        r_mode <= M_FDIV;
                    end
                end
            endcase
            if (i_ctrl.ctr_ld) begin
                r_ctr <= i_pix;
            end
            if (i_ctrl.clr) begin
                r_sw <= 39'd0;
                r_sp <= 56'sd0;
            end
        end
    end

endmodule

/* test/tileable_bilateral_filter_test.sv */
// ----------------------------------------------------------------------------
// tileable_bilateral_filter_test
// self-checking bench: loads small images into the pixel store, runs filter
// requests under many register settings and checks every result field
// against an in-bench prediction of the wrap-around bilateral filter
// ----------------------------------------------------------------------------
module tileable_bilateral_filter_test;

    // request kinds
    localparam bit       REQ_WRITE  = 1'b0;
    localparam bit       REQ_FILTER = 1'b1;

    localparam int ITEM_GOAL   = 1400;
    localparam int STALL_LIMIT = 6000;

    typedef struct {
        bit              kind;
        bit [6:0]        x;
        bit [6:0]        y;
        bit [15:0]       ch[4];
    } t_pixel_req;

    typedef struct {
        bit [6:0]        x;
        bit [6:0]        y;
        bit [15:0]       ch[4];
    } t_filtered_px;

    // ------------------------------------------------------------------------
    // scoreboard: shadow pixel store, shadow registers, queue of expected pixels
    // ------------------------------------------------------------------------
    class filter_scoreboard;
        bit [63:0]    shadow_store[tbf_pkg::MAX_W*tbf_pkg::MAX_H];
        int unsigned  reg_w = 128, reg_h = 128, reg_r = 1, reg_t = 256;
        t_filtered_px pending_px[$];
        int           errors;
        int           n_checked;

        function void set_reg(bit [1:0] idx, bit [15:0] val);
            case (idx)
                tbf_pkg::REG_WIDTH:  reg_w = val[7:0];
                tbf_pkg::REG_HEIGHT: reg_h = val[7:0];
                tbf_pkg::REG_RADIUS: reg_r = val[2:0];
                tbf_pkg::REG_THRESH: reg_t = val;
                default:             reg_t = reg_t;
            endcase
        endfunction

        // q0.16 gaussian by radius and squared distance
        function longint gauss(int unsigned r, int unsigned d2);
            longint g;
            g = 0;
            if (d2 == 0) g = 65535;
            else if (d2 == 1) begin
                case (r)
                    2: g = 34;   3: g = 420;  4: g = 1484;
                    5: g = 3165; 6: g = 5245; 7: g = 7524;
                    default: g = 0;
                endcase
            end else if (d2 == 2) begin
                case (r)
                    3: g = 3;   4: g = 34;  5: g = 153;
                    6: g = 420; 7: g = 864;
                    default: g = 0;
                endcase
            end else if (d2 == 4) begin
                g = (r == 6) ? 3 : (r == 7) ? 11 : 0;
            end else if (d2 == 5) begin
                g = (r == 7) ? 1 : 0;
            end
            return g;
        endfunction

        function void note(t_pixel_req q);
            int unsigned  w, h, r, t, cx, cy, nx, ny, reach;
            int           dx, dy, centre, p, ad;
            longint       s, wt, sum_p;
            longint unsigned sum_w, mag, quo;
            longint       val;
            t_filtered_px e;
            if (q.kind == REQ_WRITE) begin
                shadow_store[{q.y, q.x}] = {q.ch[3], q.ch[2], q.ch[1], q.ch[0]};
                return;
            end
            w = (reg_w == 0) ? 1 : (reg_w > tbf_pkg::MAX_W) ? tbf_pkg::MAX_W : reg_w;
            h = (reg_h == 0) ? 1 : (reg_h > tbf_pkg::MAX_H) ? tbf_pkg::MAX_H : reg_h;
            r = (reg_r == 0) ? 1 : reg_r;
            t = (reg_t == 0) ? 1 : reg_t;
            cx = q.x % w;
            cy = q.y % h;
            // weights vanish beyond squared distance five
            reach = (r < 2) ? r : 2;
            e.x = q.x;
            e.y = q.y;
            for (int c = 0; c < 4; c++) begin
                centre = $signed(shadow_store[cy*tbf_pkg::MAX_W + cx][16*c +: 16]);
                sum_w = 0;
                sum_p = 0;
                for (dy = -int'(reach); dy <= int'(reach); dy++) begin
                    ny = (int'(cy) + int'(h)*tbf_pkg::MAX_R + dy) % h;
                    for (dx = -int'(reach); dx <= int'(reach); dx++) begin
                        nx = (int'(cx) + int'(w)*tbf_pkg::MAX_R + dx) % w;
                        p  = $signed(shadow_store[ny*tbf_pkg::MAX_W + nx][16*c +: 16]);
                        ad = (centre > p) ? centre - p : p - centre;
                        s  = (ad <= t) ? ((longint'(t) - ad) <<< 16) / t : 0;
                        wt = s * gauss(r, dx*dx + dy*dy);
                        sum_w += wt;
                        sum_p += wt * p;
                    end
                end
                mag = (sum_p < 0) ? -sum_p : sum_p;
                quo = (2*mag + sum_w) / (2*sum_w);
                val = (sum_p < 0) ? -longint'(quo) : longint'(quo);
                if (val > 32767) val = 32767;
                if (val < -32768) val = -32768;
                e.ch[c] = val[15:0];
            end
            pending_px.push_back(e);
        endfunction

        function void check(t_filtered_px got);
            t_filtered_px e;
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $realtime, got.x, got.y);
                errors++;
                return;
            end
            e = pending_px.pop_front();
            n_checked++;
            if (got.x != e.x) begin
                $display("%0t: out_x expected %0d actual %0d", $realtime, e.x, got.x);
                errors++;
            end
            if (got.y != e.y) begin
                $display("%0t: out_y expected %0d actual %0d", $realtime, e.y, got.y);
                errors++;
            end
            for (int c = 0; c < 4; c++)
                if (got.ch[c] != e.ch[c]) begin
                    $display("%0t: out_ch%0d at (%0d,%0d) expected %0d actual %0d",
                             $realtime, c, e.x, e.y, $signed(e.ch[c]), $signed(got.ch[c]));
                    errors++;
                end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic [6:0]         i_pos_x;
    logic [6:0]         i_pos_y;
    logic signed [15:0] i_in_ch0, i_in_ch1, i_in_ch2, i_in_ch3;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               o_strobe;
    logic [6:0]         o_out_x;
    logic [6:0]         o_out_y;
    logic signed [15:0] o_out_ch0, o_out_ch1, o_out_ch2, o_out_ch3;

    tileable_bilateral_filter u_top (.*);

    filter_scoreboard sb = new();

    int n_writes, n_filters, n_phases;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result monitor: the strobe lasts one cycle and cannot be held off
    always @(posedge i_clk) begin
        t_filtered_px got;
        if (i_rst_n && o_strobe) begin
            got.x = o_out_x;
            got.y = o_out_y;
            got.ch[0] = o_out_ch0;
            got.ch[1] = o_out_ch1;
            got.ch[2] = o_out_ch2;
            got.ch[3] = o_out_ch3;
            sb.check(got);
        end
    end

    // watchdog on cycles with no request, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("timeout with %0d results outstanding", sb.pending_px.size());
                $display("tileable_bilateral_filter test failed");
                $finish;
            end
        end
    end

    // one request: random gap, then hold start until accepted
    task automatic send(t_pixel_req q);
        repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19)) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_req_type = q.kind;
        i_pos_x    = q.x;
        i_pos_y    = q.y;
        i_in_ch0   = q.ch[0];
        i_in_ch1   = q.ch[1];
        i_in_ch2   = q.ch[2];
        i_in_ch3   = q.ch[3];
        do @(posedge i_clk); while (busy);
        sb.note(q);
        if (q.kind == REQ_WRITE) n_writes++;
        else n_filters++;
        // start stays high into the next negedge; send or drain lowers it
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_px.size() != 0) @(posedge i_clk);
        // writes leave no result, let the block settle before touching registers
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [15:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // channel value near a base so range weights land inside the threshold
    function automatic bit [15:0] pix_val(int base, int spread, bit extreme);
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return extreme ? 16'h7fff : 16'(base);
            2: return extreme ? 16'h8000 : 16'(base + 1);
            default: return 16'(base + int'($urandom_range(0, 2*spread)) - spread);
        endcase
    endfunction

    // one setting: fill the image in use, then filters mixed with rewrites
    task automatic run_phase(bit [15:0] wv, bit [15:0] hv, bit [15:0] rv,
                             bit [15:0] tv, int n_req, bit extreme);
        int unsigned w, h;
        int          base, spread;
        t_pixel_req  q;
        drain();
        write_reg(tbf_pkg::REG_WIDTH, wv);
        write_reg(tbf_pkg::REG_HEIGHT, hv);
        write_reg(tbf_pkg::REG_RADIUS, rv);
        write_reg(tbf_pkg::REG_THRESH, tv);
        n_phases++;
        w = (wv[7:0] == 0) ? 1 : (wv[7:0] > tbf_pkg::MAX_W) ? tbf_pkg::MAX_W : wv[7:0];
        h = (hv[7:0] == 0) ? 1 : (hv[7:0] > tbf_pkg::MAX_H) ? tbf_pkg::MAX_H : hv[7:0];
        base   = $signed(16'($urandom()));
        spread = (tv == 0) ? 1 : tv;
        // every pixel a window can reach gets written first
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                q.kind = REQ_WRITE;
                q.x = 7'(x);
                q.y = 7'(y);
                for (int c = 0; c < 4; c++) q.ch[c] = pix_val(base, spread, extreme);
                send(q);
            end
        for (int i = 0; i < n_req; i++) begin
            q.kind = ($urandom_range(0, 3) == 0) ? REQ_WRITE : REQ_FILTER;
            // filter centers sometimes lie outside the image in use
            if ($urandom_range(0, 2) == 0) begin
                q.x = 7'($urandom());
                q.y = 7'($urandom());
            end else begin
                q.x = 7'($urandom_range(0, w - 1));
                q.y = 7'($urandom_range(0, h - 1));
            end
            for (int c = 0; c < 4; c++) q.ch[c] = pix_val(base, spread, extreme);
            send(q);
        end
    endtask

    function automatic bit [15:0] pick_thresh();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'($urandom_range(1, 255));
            2: return 16'($urandom_range(256, 4096));
            3: return 16'd65535;
            4: return 16'd0;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        start      = 1'b0;
        i_req_type = REQ_WRITE;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_in_ch0   = '0;
        i_in_ch1   = '0;
        i_in_ch2   = '0;
        i_in_ch3   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = tbf_pkg::REG_WIDTH;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: tiny images, extreme values, zero and oversized registers,
        // windows wider than the image
        run_phase(16'd2, 16'd2, 16'd7, 16'd65535, 6, 1'b1);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 3, 1'b1);
        run_phase(16'd3, 16'd1, 16'd1, 16'd256, 4, 1'b1);

        // edge dimensions: one full row, one full column
        run_phase(16'd200, 16'd1, 16'd3, pick_thresh(), 20, 1'b0);
        run_phase(16'd1, 16'd128, 16'd6, pick_thresh(), 20, 1'b0);

        // random settings on small images keep the fill cost low
        while (n_writes + n_filters < ITEM_GOAL)
            run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                      16'($urandom_range(0, 7)), pick_thresh(),
                      $urandom_range(10, 40), $urandom_range(0, 4) == 0);

        drain();
        $display("covered %0d settings, %0d pixel writes, %0d filter requests, %0d results",
                 n_phases, n_writes, n_filters, sb.n_checked);
        if (sb.errors == 0 && sb.pending_px.size() == 0)
            $display("tileable_bilateral_filter test passed");
        else
            $display("tileable_bilateral_filter test failed");
        $finish;
    end

endmodule

/* files.f */
src/tbf_pkg.sv
src/tbf_ram.sv
src/tbf_chan.sv
src/tileable_bilateral_filter.sv
test/tileable_bilateral_filter_test.sv
